// ===== src/psfe_pkg.sv =====
// Shared types, constants and helper functions for the prefix/suffix field extractor.
`timescale 1ns / 1ps
`default_nettype none

package psfe_pkg;

    localparam int PATTERN_BYTES = 8;
    localparam int OFFSET_BITS   = 16;

    localparam int PAT_W   = 64;
    localparam int CNT_W   = 4;
    localparam int LEN_W   = 16;
    localparam int IDX_W   = 3;

    localparam logic [LEN_W-1:0] MAX_CONTENT_RESET = 16'hFFFF;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_PREFIX_PATTERN = 3'd0;
    localparam logic [IDX_W-1:0] REG_PREFIX_COUNT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SUFFIX_PATTERN = 3'd2;
    localparam logic [IDX_W-1:0] REG_SUFFIX_COUNT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_CONTENT    = 3'd4;

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_CONTENT = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [PAT_W-1:0] prefix_pattern;
        logic [CNT_W-1:0] prefix_count;
        logic [PAT_W-1:0] suffix_pattern;
        logic [CNT_W-1:0] suffix_count;
        logic [LEN_W-1:0] max_content;
    } cfg_t;

    typedef struct packed {
        logic             emit;
        logic             found;
        logic [LEN_W-1:0] start_offset;
        logic [LEN_W-1:0] content_length;
    } result_t;

    function automatic logic [7:0] pat_byte(logic [PAT_W-1:0] pat, logic [2:0] i);
        return pat[{i, 3'b000} +: 8];
    endfunction

    function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'(PATTERN_BYTES);
        return (c > lim) ? lim : c;
    endfunction

endpackage

`default_nettype wire

// ===== src/psfe_cfg_regs.sv =====
// Configuration register file for the field extractor.
`timescale 1ns / 1ps
`default_nettype none

module psfe_cfg_regs
    import psfe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [PAT_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prefix_pattern <= '0;
            cfg_reg.prefix_count   <= '0;
            cfg_reg.suffix_pattern <= '0;
            cfg_reg.suffix_count   <= '0;
            cfg_reg.max_content    <= MAX_CONTENT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PREFIX_PATTERN: cfg_reg.prefix_pattern <= cfg_data;
                REG_PREFIX_COUNT:   cfg_reg.prefix_count   <= cfg_data[CNT_W-1:0];
                REG_SUFFIX_PATTERN: cfg_reg.suffix_pattern <= cfg_data;
                REG_SUFFIX_COUNT:   cfg_reg.suffix_count   <= cfg_data[CNT_W-1:0];
                REG_MAX_CONTENT:    cfg_reg.max_content    <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/psfe_step.sv =====
// Per-buffer match state and the single-byte step logic.
`timescale 1ns / 1ps
`default_nettype none

module psfe_step
    import psfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       step,
    input  wire logic [7:0] data,
    input  wire logic       last,
    output result_t         res
);

    phase_t                 phase_reg, phase_next, phase_after;
    logic [CNT_W-1:0]       pre_prog_reg, pre_prog_next;
    logic [CNT_W-1:0]       sfx_prog_reg, sfx_prog_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next, start_after;
    logic [LEN_W-1:0]       count_reg, count_next, count_after;

    logic [CNT_W-1:0]       pc, sc;
    logic                   pre_active, pre_skip, pre_consume, pre_match, pre_done_now;
    logic [CNT_W-1:0]       pre_prog_new;
    logic                   content_active, sfx_has, sfx_already, sfx_match, sfx_complete;
    logic [CNT_W-1:0]       sfx_prog_inc;
    logic                   overflow, count_inc, content_emit, content_found, last_emit;
    logic [OFFSET_BITS+LEN_W-1:0] start_wide;

    assign pc = clamp_count(cfg.prefix_count);
    assign sc = clamp_count(cfg.suffix_count);

    assign pre_active   = (phase_reg == PH_PREFIX);
    assign pre_skip     = pre_active && (pre_prog_reg >= pc);
    assign pre_consume  = pre_active && !pre_skip;
    assign pre_match    = (data == pat_byte(cfg.prefix_pattern, pre_prog_reg[2:0]));
    assign pre_prog_new = pre_match ? pre_prog_reg + 1'b1 : '0;
    assign pre_done_now = pre_consume && (pre_prog_new >= pc);

    // a skipped prefix (already matched) lets the same byte go to content
    assign content_active = (phase_reg == PH_CONTENT) || pre_skip;
    assign sfx_has        = (sc != '0);
    assign sfx_already    = sfx_has && (sfx_prog_reg >= sc);
    assign sfx_match      = content_active && sfx_has && !sfx_already
                            && (data == pat_byte(cfg.suffix_pattern, sfx_prog_reg[2:0]));
    assign sfx_prog_inc   = sfx_prog_reg + 1'b1;
    assign sfx_complete   = sfx_match && (sfx_prog_inc >= sc);
    // count + 1 > max  <=>  count >= max
    assign overflow       = (count_reg >= cfg.max_content);
    assign count_inc      = content_active && !sfx_already && !sfx_match && !overflow;
    assign content_emit   = content_active
                            && (sfx_already || sfx_complete || (!sfx_match && overflow));
    assign content_found  = sfx_already || sfx_complete || (!sfx_match && overflow && !sfx_has);

    assign count_after = count_reg + LEN_W'(count_inc);

    always_comb
    begin
        start_after = start_reg;
        if (pre_skip)
            start_after = pos_reg;
        else if (pre_done_now)
            start_after = pos_reg + 1'b1;
    end

    always_comb
    begin
        phase_after = phase_reg;
        if (content_emit)
            phase_after = PH_DONE;
        else if (pre_skip || pre_done_now)
            phase_after = PH_CONTENT;
    end

    assign last_emit = last && !content_emit && (phase_reg != PH_DONE);

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        pre_prog_next = pre_prog_reg;
        sfx_prog_next = sfx_prog_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        count_next    = count_reg;
        if (step)
        begin
            if (last)
            begin
                phase_next    = PH_PREFIX;
                pre_prog_next = '0;
                sfx_prog_next = '0;
                pos_next      = '0;
                start_next    = '0;
                count_next    = '0;
            end
            else
            begin
                phase_next    = phase_after;
                pre_prog_next = pre_consume ? pre_prog_new : pre_prog_reg;
                sfx_prog_next = sfx_match ? sfx_prog_inc : sfx_prog_reg;
                pos_next      = pos_reg + 1'b1;
                start_next    = start_after;
                count_next    = count_after;
            end
        end
    end

    // result outputs
    always_comb
    begin
        start_wide         = {{LEN_W{1'b0}}, start_after};
        res.emit           = step && (content_emit || last_emit);
        res.found          = 1'b0;
        res.start_offset   = start_wide[LEN_W-1:0];
        res.content_length = count_after;
        if (content_emit)
            res.found = content_found;
        else if (phase_after == PH_CONTENT)
            res.found = !sfx_has;
        else
        begin
            res.start_offset   = '0;
            res.content_length = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_PREFIX;
            pre_prog_reg <= '0;
            sfx_prog_reg <= '0;
            pos_reg      <= '0;
            start_reg    <= '0;
            count_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pre_prog_reg <= pre_prog_next;
            sfx_prog_reg <= sfx_prog_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/prefix_suffix_field_extractor_unit.sv =====
// Prefix/suffix field extractor: input register, step logic, result register.
// Output: out_valid rises once the byte that ends the field has passed the byte register
// and the step logic into the result register. Throughput: one byte per cycle; the byte
// register and result register both advance whenever the result register is empty or being taken.
// Reset (rst_n, async, low): registers to defaults (max_content 65535), prefix search.
`timescale 1ns / 1ps
`default_nettype none

module prefix_suffix_field_extractor_unit
    import psfe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [PAT_W-1:0] cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  found,
    output logic [LEN_W-1:0]      start_offset,
    output logic [LEN_W-1:0]      content_length
);

    cfg_t    cfg;
    result_t res;

    logic             in_valid_reg;
    logic [7:0]       data_reg;
    logic             last_reg;
    logic             advance;

    logic             out_valid_reg;
    logic             found_reg;
    logic [LEN_W-1:0] start_reg;
    logic [LEN_W-1:0] length_reg;

    psfe_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psfe_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (advance),
        .data  (data_reg),
        .last  (last_reg),
        .res   (res)
    );

    // the held byte moves on once the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.emit)
        begin
            found_reg  <= res.found;
            start_reg  <= res.start_offset;
            length_reg <= res.content_length;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign start_offset   = start_reg;
    assign content_length = length_reg;

endmodule

`default_nettype wire
